// File: src/flacpr_pkg.sv
// Shared constants, types and coefficient tables for the FLAC predictor restore block.
`default_nettype none

package flacpr_pkg;

  // Sizes of the history and coefficient stores
  localparam int MAX_ORDER       = 32;
  localparam int IDX_W           = $clog2(MAX_ORDER);
  localparam int TAP_W           = $clog2(MAX_ORDER + 1);
  localparam int FIXED_MAX_ORDER = 4;

  // Field widths
  localparam int SAMPLE_W = 32;
  localparam int COEF_W   = 15;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = 64;
  localparam int REQ_W    = 2;
  localparam int CIDX_W   = 5;
  localparam int ORDER_W  = 6;
  localparam int SHIFT_W  = 5;
  localparam int WASTE_W  = 5;

  // Port widths
  localparam int IN_DATA_W  = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // Request kinds carried on the input user field
  localparam logic [REQ_W-1:0] REQ_LOAD_COEF = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WARM_UP   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RESIDUAL  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WASTE = 2'd3;

  // Predictor modes
  localparam logic MODE_FIXED = 1'b0;
  localparam logic MODE_LPC   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_SHIFT,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;    // latch a warm-up sample or residual, clear the accumulator
    logic load_coef;  // write one coefficient slot
    logic mac_step;   // multiply one tap
    logic do_shift;   // apply the quantization shift to the sum
    logic finish;     // form the sample, push history, load the output register
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic taps_done;  // every tap of the current prediction has been issued
    logic out_free;   // the output register can take a new sample
  } dp_status_t;

  // Fixed polynomial predictor taps expressed as small coefficients
  function automatic logic signed [COEF_W-1:0] fixed_coef(
    input logic [ORDER_W-1:0] order,
    input logic [IDX_W-1:0]   tap
  );
    logic signed [COEF_W-1:0] c;
    c = '0;
    case (order)
      6'd1: begin
        if (tap == IDX_W'(0)) c = 15'sd1;
      end
      6'd2: begin
        if (tap == IDX_W'(0)) c = 15'sd2;
        if (tap == IDX_W'(1)) c = -15'sd1;
      end
      6'd3: begin
        if (tap == IDX_W'(0)) c = 15'sd3;
        if (tap == IDX_W'(1)) c = -15'sd3;
        if (tap == IDX_W'(2)) c = 15'sd1;
      end
      6'd4: begin
        if (tap == IDX_W'(0)) c = 15'sd4;
        if (tap == IDX_W'(1)) c = -15'sd6;
        if (tap == IDX_W'(2)) c = 15'sd4;
        if (tap == IDX_W'(3)) c = -15'sd1;
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/flacpr_ctrl.sv
// Controller state machine that sequences requests through the predictor datapath.
`default_nettype none

module flacpr_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [flacpr_pkg::REQ_W-1:0] in_req,
  input  wire flacpr_pkg::dp_status_t     status,
  output flacpr_pkg::dp_cmd_t             cmd
);
  import flacpr_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && in_req == REQ_RESIDUAL) begin
          state_next = ST_MAC;
        end else if (accept && in_req == REQ_WARM_UP) begin
          state_next = ST_FINISH;
        end
      end
      ST_MAC: begin
        if (status.taps_done) state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.capture   = accept && (in_req == REQ_RESIDUAL || in_req == REQ_WARM_UP);
        cmd.load_coef = accept && (in_req == REQ_LOAD_COEF);
      end
      ST_MAC: begin
        cmd.mac_step = !status.taps_done;
      end
      ST_SHIFT: begin
        cmd.do_shift = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = status.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: src/flacpr_dp.sv
// Datapath: configuration, coefficient and history stores, shared multiply-accumulate.
`default_nettype none

module flacpr_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire flacpr_pkg::dp_cmd_t               cmd,
  output flacpr_pkg::dp_status_t                 status,
  input  wire logic                              cfg_we,
  input  wire logic [flacpr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [flacpr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [flacpr_pkg::REQ_W-1:0]      in_req,
  input  wire logic [flacpr_pkg::CIDX_W-1:0]     in_coef_index,
  input  wire logic [flacpr_pkg::SAMPLE_W-1:0]   in_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [flacpr_pkg::SAMPLE_W-1:0]        out_sample
);
  import flacpr_pkg::*;

  // Configuration registers
  logic                      mode;
  logic [ORDER_W-1:0]        order;
  logic signed [SHIFT_W-1:0] qshift;
  logic [WASTE_W-1:0]        wasted;

  // Stores
  logic [SAMPLE_W-1:0]     hist [MAX_ORDER];
  logic signed [COEF_W-1:0] coefs [MAX_ORDER];

  // Working registers
  logic [SAMPLE_W-1:0]     value;
  logic                    is_warm;
  logic [TAP_W-1:0]        tap;
  logic signed [PROD_W-1:0] prod;
  logic                    prod_valid;
  logic signed [ACC_W-1:0] acc;
  logic [SAMPLE_W-1:0]     pred;

  logic [TAP_W-1:0]         taps;
  logic [IDX_W-1:0]         tap_idx;
  logic signed [COEF_W-1:0] tap_coef;
  logic signed [ACC_W-1:0]  shifted;
  logic [SHIFT_W-1:0]       left_amt;
  logic [SAMPLE_W-1:0]      sample;

  // Number of taps: the LPC order saturates, a fixed order above four predicts zero
  always_comb begin
    if (mode == MODE_LPC) begin
      if (32'(order) > MAX_ORDER) taps = TAP_W'(MAX_ORDER);
      else taps = TAP_W'(order);
    end else begin
      if (32'(order) <= FIXED_MAX_ORDER) taps = TAP_W'(order);
      else taps = '0;
    end
  end

  assign tap_idx  = tap[IDX_W-1:0];
  assign tap_coef = (mode == MODE_LPC) ? coefs[tap_idx] : fixed_coef(order, tap_idx);

  assign status.taps_done = (tap == taps);
  assign status.out_free  = !out_valid || out_ready;

  // Quantization shift: right for non-negative levels, left otherwise; none in fixed mode
  assign left_amt = SHIFT_W'(0) - qshift;
  always_comb begin
    if (mode == MODE_FIXED) begin
      shifted = acc;
    end else if (!qshift[SHIFT_W-1]) begin
      shifted = acc >>> qshift[SHIFT_W-2:0];
    end else begin
      shifted = acc << left_amt;
    end
  end

  // Restored sample wraps to 32 bits
  assign sample = is_warm ? value : value + pred;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_FIXED;
      order  <= '0;
      qshift <= '0;
      wasted <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MODE:  mode   <= cfg_wdata[0];
        CFG_ORDER: order  <= cfg_wdata[ORDER_W-1:0];
        CFG_SHIFT: qshift <= cfg_wdata[SHIFT_W-1:0];
        CFG_WASTE: wasted <= cfg_wdata[WASTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Coefficient loads keep the low 15 bits; slots beyond the table are dropped
  always_ff @(posedge clk) begin
    if (cmd.load_coef && (32'(in_coef_index) < MAX_ORDER)) begin
      coefs[in_coef_index[IDX_W-1:0]] <= in_value[COEF_W-1:0];
    end
  end

  // History shift line, most recent sample in entry zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_ORDER; k++) hist[k] <= '0;
    end else if (cmd.finish) begin
      hist[0] <= sample;
      for (int k = 1; k < MAX_ORDER; k++) hist[k] <= hist[k-1];
    end
  end

  // Capture of the incoming item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      value   <= in_value;
      is_warm <= (in_req == REQ_WARM_UP);
    end
  end

  // Multiply one tap per cycle, accumulate the previous product
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      tap        <= '0;
    end else if (cmd.capture) begin
      prod_valid <= 1'b0;
      tap        <= '0;
    end else begin
      prod_valid <= cmd.mac_step;
      if (cmd.mac_step) tap <= tap + TAP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_step) begin
      prod <= tap_coef * $signed(hist[tap_idx]);
    end
    if (cmd.capture) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Shifted prediction, only its low word reaches the sample
  always_ff @(posedge clk) begin
    if (cmd.do_shift) begin
      pred <= shifted[SAMPLE_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_sample <= sample << wasted;
    end
  end

endmodule

`default_nettype wire

// File: src/flac_predictor_reconstruction_unit.sv
// Top level of the FLAC fixed and LPC predictor restore block.
`default_nettype none

// Restores one channel's samples from residuals with a fixed polynomial predictor
// (order 0 to 4) or a quantized LPC predictor (order 1 to 32). Input transactions carry a
// request kind in tuser: coefficient load, warm-up sample or residual. A coefficient load
// returns nothing. A residual passes through the single shared multiplier, which handles
// one history tap per cycle, followed by the shift and the final add. Each warm-up or
// restored sample returns one output transaction, shifted left by the wasted bits. A
// finished sample waits in the output register while the next input transaction is taken.
// Configuration writes are taken at any time but must only be issued while the block is
// idle. Coefficient slots must be loaded before an LPC prediction reads them.
module flac_predictor_reconstruction_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Input stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [flacpr_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // coef_index[4:0], value[36:5]
  input  wire logic [flacpr_pkg::REQ_W-1:0]       s_axis_tuser,  // req_type[1:0]
  // Output stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [flacpr_pkg::SAMPLE_W-1:0]         m_axis_tdata,  // sample[31:0]
  // Configuration writes
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [flacpr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [flacpr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import flacpr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Configuration writes are always accepted
  assign cfg_ready = 1'b1;

  flacpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_req   (s_axis_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  flacpr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_valid),
    .cfg_idx       (cfg_index),
    .cfg_wdata     (cfg_data),
    .in_req        (s_axis_tuser),
    .in_coef_index (s_axis_tdata[CIDX_W-1:0]),
    .in_value      (s_axis_tdata[CIDX_W+SAMPLE_W-1:CIDX_W]),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_sample    (m_axis_tdata)
  );

endmodule

`default_nettype wire

// File: tb/flac_predictor_reconstruction_unit_tb.sv
// Self-checking testbench for the FLAC fixed and LPC predictor restore block.
`timescale 1ns / 100ps

module flac_predictor_reconstruction_unit_tb;
  import flacpr_pkg::*;

  // Request kind that the block must ignore
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS   = 1300;
  localparam int SETTLE_CYCLES  = 40;    // margin for the longest residual to finish
  localparam int SQUEEZE_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    bit                        is_cfg;
    logic                      mode;
    logic [ORDER_W-1:0]        order;
    logic signed [SHIFT_W-1:0] shift;
    logic [WASTE_W-1:0]        waste;
    logic [REQ_W-1:0]          req;
    logic [CIDX_W-1:0]         idx;
    logic [SAMPLE_W-1:0]       val;
    bit                        typed;
    logic [SAMPLE_W-1:0]       smp;
  } plan_row_t;

  logic clk;
  logic rst = 1'b1;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [REQ_W-1:0]      s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [SAMPLE_W-1:0]   m_axis_tdata;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  // Predictor state, kept in step with the block
  logic signed [SAMPLE_W-1:0] hist [MAX_ORDER] = '{default: '0};
  logic signed [COEF_W-1:0]   coef_table [MAX_ORDER];
  logic [MAX_ORDER-1:0]       coef_loaded = '0;
  logic                       cur_mode    = MODE_FIXED;
  logic [ORDER_W-1:0]         cur_order   = '0;
  logic signed [SHIFT_W-1:0]  cur_shift   = '0;
  logic [WASTE_W-1:0]         cur_waste   = '0;

  logic [SAMPLE_W-1:0] pending_samples [$];
  plan_row_t           directed_plan [$];

  int  mismatch_count  = 0;
  int  samples_checked = 0;
  int  items_sent      = 0;
  int  settings_count  = 0;
  bit  squeeze_req     = 1'b0;

  flac_predictor_reconstruction_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Applies one accepted input transaction to the predictor state.
  // Returns 1 and the shifted sample when the transaction produces an output.
  function automatic bit restore_sample(input logic [REQ_W-1:0] req,
                                        input logic [CIDX_W-1:0] idx,
                                        input logic [SAMPLE_W-1:0] val,
                                        output logic [SAMPLE_W-1:0] smp);
    logic signed [63:0] pred;
    logic signed [63:0] h [4];
    logic [SAMPLE_W-1:0] s;
    int taps, k;
    pred = '0;
    smp  = '0;
    s    = '0;
    case (req)
      REQ_LOAD_COEF: begin
        coef_table[idx]  = val[COEF_W-1:0];
        coef_loaded[idx] = 1'b1;
        return 1'b0;
      end
      REQ_WARM_UP: s = val;
      REQ_RESIDUAL: begin
        if (cur_mode == MODE_FIXED) begin
          for (k = 0; k < 4; k++) h[k] = 64'(hist[k]);
          case (cur_order)
            6'd1: pred = h[0];
            6'd2: pred = 2 * h[0] - h[1];
            6'd3: pred = 3 * h[0] - 3 * h[1] + h[2];
            6'd4: pred = 4 * h[0] - 6 * h[1] + 4 * h[2] - h[3];
            default: pred = '0;
          endcase
        end else begin
          // Orders past the history depth use every tap
          taps = (cur_order > MAX_ORDER) ? MAX_ORDER : int'(cur_order);
          for (k = 0; k < taps; k++) pred += 64'(coef_table[k]) * 64'(hist[k]);
          if (!cur_shift[SHIFT_W-1]) pred = pred >>> cur_shift[SHIFT_W-2:0];
          else pred = pred << (-int'(cur_shift));
        end
        s = val + pred[SAMPLE_W-1:0];
      end
      default: return 1'b0;
    endcase
    // History keeps the unshifted sample, newest at entry 0
    for (k = MAX_ORDER - 1; k > 0; k--) hist[k] = hist[k-1];
    hist[0] = s;
    smp = s << cur_waste;
    return 1'b1;
  endfunction

  function automatic void cfg_row(input logic mode, input logic [ORDER_W-1:0] order,
                                  input logic signed [SHIFT_W-1:0] shift,
                                  input logic [WASTE_W-1:0] waste);
    directed_plan.push_back('{1'b1, mode, order, shift, waste, '0, '0, '0, 1'b0, '0});
  endfunction

  function automatic void item_row(input logic [REQ_W-1:0] req, input logic [CIDX_W-1:0] idx,
                                   input logic [SAMPLE_W-1:0] val, input bit typed,
                                   input logic [SAMPLE_W-1:0] smp);
    directed_plan.push_back('{1'b0, MODE_FIXED, '0, '0, '0, req, idx, val, typed, smp});
  endfunction

  // Random word, mostly sign-extended from a narrow width, sometimes full range.
  function automatic logic [SAMPLE_W-1:0] rand_word(input int narrow);
    logic [SAMPLE_W-1:0] w;
    w = $urandom;
    if ($urandom_range(0, 9) < 7) w = $signed(w << (SAMPLE_W - narrow)) >>> (SAMPLE_W - narrow);
    return w;
  endfunction

  // Offers one input transaction and records its expected output on acceptance.
  task automatic send_item(input logic [REQ_W-1:0] req, input logic [CIDX_W-1:0] idx,
                           input logic [SAMPLE_W-1:0] val, input bit typed,
                           input logic [SAMPLE_W-1:0] typed_smp);
    logic [SAMPLE_W-1:0] smp;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {{(IN_DATA_W - SAMPLE_W - CIDX_W){1'b0}}, val, idx};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    if (restore_sample(req, idx, val, smp)) pending_samples.push_back(typed ? typed_smp : smp);
    items_sent++;
  endtask

  // Random pause between input transactions: mostly none, a few long ones.
  task automatic idle_gap(input bit no_gaps);
    int r, gap;
    if (no_gaps) return;
    r   = $urandom_range(0, 99);
    gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering input until every expected sample is out and the block has settled.
  task automatic wait_for_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_index <= index;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      CFG_MODE:  cur_mode  = data[0];
      CFG_ORDER: cur_order = data;
      CFG_SHIFT: cur_shift = data[SHIFT_W-1:0];
      CFG_WASTE: cur_waste = data[WASTE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_settings(input logic mode, input logic [ORDER_W-1:0] order,
                                  input logic signed [SHIFT_W-1:0] shift,
                                  input logic [WASTE_W-1:0] waste);
    write_reg(CFG_MODE, {5'b0, mode});
    write_reg(CFG_ORDER, order);
    write_reg(CFG_SHIFT, {1'b0, shift});
    write_reg(CFG_WASTE, {1'b0, waste});
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  // Output side: compare each sample transaction with the oldest expectation.
  always @(posedge clk) begin : check_output
    logic [SAMPLE_W-1:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_samples.size() == 0) begin
        $error("sample: no transaction expected, actual %h", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_samples.pop_front();
        if (m_axis_tdata !== want) begin
          $error("sample: expected %h, actual %h", want, m_axis_tdata);
          mismatch_count++;
        end
        samples_checked++;
      end
    end
  end

  // Output ready pattern: stretches of steady acceptance, random stalls,
  // and one long hold-off on request while the input keeps streaming.
  initial begin : output_pacing
    int  hold_left, stretch_left, r;
    bit  steady;
    hold_left    = 0;
    stretch_left = 0;
    steady       = 1'b0;
    forever begin
      @(posedge clk);
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(50, 300);
        steady       = ($urandom_range(0, 2) == 0);
      end
      stretch_left--;
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold_left   = SQUEEZE_CYCLES;
      end
      r = $urandom_range(0, 99);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (steady) begin
        m_axis_tready <= 1'b1;
      end else if (r < 3) begin
        hold_left = $urandom_range(5, 40);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (r >= 25);
      end
    end
  end

  // Ends the run when no transaction of any kind has happened for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $error("timeout: no transaction for %0d cycles, %0d samples pending",
           WATCHDOG_LIMIT, pending_samples.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [REQ_W-1:0]          req;
    logic [CIDX_W-1:0]         idx;
    logic [SAMPLE_W-1:0]       val;
    logic                      mode;
    logic [ORDER_W-1:0]        order;
    logic signed [SHIFT_W-1:0] shift;
    logic [WASTE_W-1:0]        waste;
    int phase, taps, n_loads, n_warm, n_open, random_items, directed_items, r, k, j;
    bit no_gaps, squeeze, found;

    // Directed table, starting from the reset settings (fixed, order 0, no shifts)
    item_row(REQ_WARM_UP, 5'd0, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF);
    item_row(REQ_WARM_UP, 5'd31, 32'h8000_0000, 1'b1, 32'h8000_0000);
    item_row(REQ_RESIDUAL, 5'd0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    item_row(REQ_UNUSED, 5'd31, 32'hFFFF_FFFF, 1'b0, '0);
    // Largest and smallest coefficients, and the top slot
    item_row(REQ_LOAD_COEF, 5'd0, 32'hFFFF_3FFF, 1'b0, '0);
    item_row(REQ_LOAD_COEF, 5'd1, 32'h0000_4000, 1'b0, '0);
    item_row(REQ_LOAD_COEF, 5'd31, 32'hAAAA_AAAA, 1'b0, '0);
    // Each fixed polynomial order in turn
    cfg_row(MODE_FIXED, 6'd1, 5'sd0, 5'd0);
    item_row(REQ_WARM_UP, 5'd0, 32'd5, 1'b1, 32'd5);
    item_row(REQ_RESIDUAL, 5'd0, 32'd3, 1'b0, '0);
    cfg_row(MODE_FIXED, 6'd2, 5'sd0, 5'd0);
    item_row(REQ_RESIDUAL, 5'd0, 32'd0, 1'b0, '0);
    cfg_row(MODE_FIXED, 6'd3, 5'sd0, 5'd0);
    item_row(REQ_RESIDUAL, 5'd0, 32'h7FFF_FFFF, 1'b0, '0);
    cfg_row(MODE_FIXED, 6'd4, 5'sd0, 5'd31);
    item_row(REQ_WARM_UP, 5'd0, 32'd1, 1'b1, 32'h8000_0000);
    item_row(REQ_RESIDUAL, 5'd0, 32'h8000_0000, 1'b0, '0);
    // Fixed order above four predicts zero
    cfg_row(MODE_FIXED, 6'd5, 5'sd0, 5'd0);
    item_row(REQ_RESIDUAL, 5'd0, 32'd7, 1'b1, 32'd7);
    // LPC with no taps predicts zero
    cfg_row(MODE_LPC, 6'd0, 5'sd3, 5'd0);
    item_row(REQ_RESIDUAL, 5'd0, 32'h1234_5678, 1'b1, 32'h1234_5678);
    // LPC at both shift extremes
    cfg_row(MODE_LPC, 6'd2, 5'sd15, 5'd0);
    item_row(REQ_WARM_UP, 5'd0, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF);
    item_row(REQ_WARM_UP, 5'd0, 32'h8000_0000, 1'b1, 32'h8000_0000);
    item_row(REQ_RESIDUAL, 5'd0, 32'd0, 1'b0, '0);
    cfg_row(MODE_LPC, 6'd2, -5'sd16, 5'd1);
    item_row(REQ_RESIDUAL, 5'd0, 32'd1, 1'b0, '0);
    item_row(REQ_RESIDUAL, 5'd0, 32'hFFFF_FFFF, 1'b0, '0);
    cfg_row(MODE_LPC, 6'd1, 5'sd0, 5'd0);
    item_row(REQ_LOAD_COEF, 5'd0, 32'hFFFF_FFFF, 1'b0, '0);
    item_row(REQ_WARM_UP, 5'd0, 32'd100, 1'b1, 32'd100);
    item_row(REQ_RESIDUAL, 5'd0, 32'd0, 1'b0, '0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) begin
        wait_for_idle();
        program_settings(directed_plan[i].mode, directed_plan[i].order,
                         directed_plan[i].shift, directed_plan[i].waste);
      end else begin
        send_item(directed_plan[i].req, directed_plan[i].idx, directed_plan[i].val,
                  directed_plan[i].typed, directed_plan[i].smp);
        idle_gap(1'b0);
      end
    end
    directed_items = items_sent;

    // Random phases: each one programs new settings once the block is idle, then
    // sends a well-formed run (coefficients, warm-up, residuals) with some noise.
    phase        = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      wait_for_idle();
      squeeze = (phase == 2);
      if (squeeze) begin
        mode  = MODE_FIXED;
        order = 6'd2;
        shift = 5'sd0;
        waste = 5'd0;
      end else begin
        mode = 1'($urandom_range(0, 1));
        if (mode == MODE_FIXED) begin
          r     = $urandom_range(0, 9);
          order = (r < 8) ? ORDER_W'($urandom_range(0, 4)) :
                  (r == 8) ? ORDER_W'($urandom_range(5, 31)) : 6'd63;
        end else begin
          r = $urandom_range(0, 19);
          if (r < 12)      order = ORDER_W'($urandom_range(1, 8));
          else if (r < 15) order = ORDER_W'($urandom_range(9, 31));
          else if (r < 17) order = 6'd32;
          else if (r == 17) order = 6'd0;
          else if (r == 18) order = ORDER_W'($urandom_range(33, 62));
          else             order = 6'd63;
        end
        r = $urandom_range(0, 9);
        if (r == 0)      shift = -5'sd16;
        else if (r == 1) shift = 5'sd15;
        else if (r == 2) shift = 5'($urandom_range(0, 15) - 16);
        else             shift = 5'($urandom_range(0, 15));
        r = $urandom_range(0, 9);
        waste = (r < 6) ? 5'd0 : (r == 6) ? 5'd31 : 5'($urandom_range(1, 30));
      end
      no_gaps = squeeze || ($urandom_range(0, 3) == 0);
      program_settings(mode, order, shift, waste);
      if (squeeze) squeeze_req = 1'b1;

      if (mode == MODE_FIXED) taps = (order > FIXED_MAX_ORDER) ? FIXED_MAX_ORDER : int'(order);
      else taps = (order > MAX_ORDER) ? MAX_ORDER : int'(order);
      n_loads = (mode == MODE_LPC && $urandom_range(0, 1) == 1) ? taps : 0;
      n_warm  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, taps) : taps;
      n_open  = squeeze ? 80 : $urandom_range(20, 80);

      for (k = 0; k < n_loads + n_warm + n_open; k++) begin
        idx = CIDX_W'($urandom);
        r   = $urandom_range(0, 99);
        if (k < n_loads) begin
          req = REQ_LOAD_COEF;
          idx = CIDX_W'(k);
          val = rand_word(12);
        end else if (k < n_loads + n_warm) begin
          req = REQ_WARM_UP;
          val = rand_word(16);
        end else if (r < 4) begin
          req = REQ_UNUSED;
          val = $urandom;
        end else if (r < 10) begin
          req = REQ_LOAD_COEF;
          val = rand_word(12);
        end else if (r < 16) begin
          req = REQ_WARM_UP;
          val = rand_word(16);
        end else begin
          req = REQ_RESIDUAL;
          val = rand_word(10);
        end
        // An LPC residual must never read a slot that was not loaded yet
        if (req == REQ_RESIDUAL && mode == MODE_LPC) begin
          found = 1'b0;
          for (j = 0; j < taps && !found; j++) begin
            if (!coef_loaded[j]) begin
              found = 1'b1;
              req   = REQ_LOAD_COEF;
              idx   = CIDX_W'(j);
              val   = rand_word(12);
            end
          end
        end
        send_item(req, idx, val, 1'b0, '0);
        if (req != REQ_UNUSED) random_items++;
        idle_gap(no_gaps);
      end
      phase++;
    end

    wait_for_idle();
    $display("Run covered %0d input transactions (%0d directed) and %0d checked samples,",
             items_sent, directed_items, samples_checked);
    $display("over %0d settings of both predictors, orders up to 63, all shifts and wasted bits.",
             settings_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
src/flacpr_pkg.sv
src/flacpr_ctrl.sv
src/flacpr_dp.sv
src/flac_predictor_reconstruction_unit.sv
tb/flac_predictor_reconstruction_unit_tb.sv
